@@ rtl/core/bps_pkg.sv @@
// Shared types, codes and saturating arithmetic for the ball physics step unit.
`timescale 1ns / 1ps

package bps_pkg;

    localparam int CFG_DW = 21;
    localparam int CFG_IW = 3;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_NUDGE = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_GRAVITY = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_BOUNCE  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_WIDTH   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_HEIGHT  = 3'd4;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } t_ball;

    localparam int BALL_W = $bits(t_ball);

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor(-v * bf / 2^16), saturated
    function automatic logic signed [31:0] reflect(input logic signed [31:0] v,
                                                   input logic [16:0] bf);
        logic signed [49:0] m;
        logic signed [50:0] ng;
        logic signed [50:0] sh;
        m  = v * $signed({1'b0, bf});
        ng = -(51'(m));
        sh = ng >>> 16;
        return sat35(sh[34:0]);
    endfunction

endpackage

@@ rtl/core/ball_physics_step_unit.sv @@
// Top level of the ball physics step unit: ball state memory and step sequencer.
`timescale 1ns / 1ps

// A request is accepted when i_start is high while o_busy is low. A load is
// written in the cycle it is accepted and a nudge in S_NWR; neither gives a result.
// A tick reads each ball from the state memory, integrates it and applies the
// walls, then walks every higher-index ball: a pair that is apart is dropped in
// S_P0 or S_P4, and a touching pair also runs the 23-step square root and the
// 44-step divider. Each ball's result is shown on o_valid for one cycle and
// cannot be held off; the receiver must take it then. Ball state reads as zero
// after reset through per-entry valid bits, with no clearing pass.

module ball_physics_step_unit #(
    parameter int BALLS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_kind,
    input  logic [2:0]                  i_ball_index,
    input  logic signed [31:0]          i_pos_x,
    input  logic signed [31:0]          i_pos_y,
    input  logic signed [31:0]          i_vel_x,
    input  logic signed [31:0]          i_vel_y,
    input  logic                        i_cfg_we,
    input  logic [bps_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [bps_pkg::CFG_DW-1:0]  i_cfg_data,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic [2:0]                  o_out_index,
    output logic signed [31:0]          o_out_x,
    output logic signed [31:0]          o_out_y,
    output logic                        o_last_ball
);

    localparam int AW = $clog2(BALLS);
    localparam int CW = $clog2(BALLS + 1);
    localparam int IW = (CW > 3) ? CW : 3;

    typedef enum logic [18:0] {
        S_IDLE = 19'b0000000000000000001,
        S_NWR  = 19'b0000000000000000010,
        S_RDA  = 19'b0000000000000000100,
        S_INT  = 19'b0000000000000001000,
        S_WY   = 19'b0000000000000010000,
        S_WX   = 19'b0000000000000100000,
        S_KRD  = 19'b0000000000001000000,
        S_P0   = 19'b0000000000010000000,
        S_P1   = 19'b0000000000100000000,
        S_P2   = 19'b0000000001000000000,
        S_P3   = 19'b0000000010000000000,
        S_P4   = 19'b0000000100000000000,
        S_SQ   = 19'b0000001000000000000,
        S_OV   = 19'b0000010000000000000,
        S_MX   = 19'b0000100000000000000,
        S_MY   = 19'b0001000000000000000,
        S_DIV  = 19'b0010000000000000000,
        S_UPD  = 19'b0100000000000000000,
        S_WRA  = 19'b1000000000000000000
    } t_state;

    t_state r_state;

    logic [15:0] r_gravity;
    logic [16:0] r_bounce;
    logic [20:0] r_radius;
    logic [7:0]  r_width;
    logic [7:0]  r_height;

    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_k;
    logic [BALLS-1:0] r_valid;
    logic [AW-1:0]    r_rd_addr;
    logic [AW-1:0]    r_idx;
    logic signed [31:0] r_nvx;
    logic signed [31:0] r_nvy;

    bps_pkg::t_ball r_a;
    bps_pkg::t_ball r_b;
    logic r_wy;
    logic r_wx;

    logic signed [22:0] r_dx;
    logic signed [22:0] r_dy;
    logic [43:0] r_sqx;
    logic [43:0] r_sqy;
    logic [43:0] r_rs2;
    logic [45:0] r_sqn;
    logic [45:0] r_sqres;
    logic [45:0] r_sqbit;
    logic [5:0]  r_cnt;
    logic [22:0] r_d;
    logic [21:0] r_ov;
    logic [43:0] r_dqx;
    logic [43:0] r_dqy;
    logic [23:0] r_remx;
    logic [23:0] r_remy;
    logic [23:0] r_div;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [bps_pkg::BALL_W-1:0] ram_wdata;
    logic [AW-1:0]             rd_addr;
    logic [bps_pkg::BALL_W-1:0] ram_q;
    bps_pkg::t_ball            rd;

    bps_pkg::t_ball            n_a;
    bps_pkg::t_ball            n_b;

    logic [IW-1:0] idx_w;
    logic [IW-1:0] out_idx_w;
    logic          idx_ok;
    logic          accept;
    logic [21:0]   rs;

    assign idx_w     = IW'(i_ball_index);
    assign out_idx_w = IW'(r_i);
    assign idx_ok    = idx_w < IW'(BALLS);
    assign accept    = i_start && (r_state == S_IDLE);
    assign rs        = {r_radius, 1'b0};
    assign rd        = r_valid[r_rd_addr] ? bps_pkg::t_ball'(ram_q) : '0;
    assign o_busy    = (r_state != S_IDLE);

    bps_ram #(
        .WIDTH (bps_pkg::BALL_W),
        .DEPTH (BALLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // memory port steering
    always_comb begin
        rd_addr   = r_i[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_i[AW-1:0];
        ram_wdata = r_a;
        case (r_state)
            S_IDLE: begin
                rd_addr   = idx_w[AW-1:0];
                ram_waddr = idx_w[AW-1:0];
                ram_we    = accept && (i_kind == bps_pkg::KIND_LOAD) && idx_ok;
                ram_wdata = {i_pos_x, i_pos_y, i_vel_x, i_vel_y};
            end
            S_NWR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {rd.px, rd.py,
                             bps_pkg::sat35(35'(rd.vx) + 35'(r_nvx)),
                             bps_pkg::sat35(35'(rd.vy) + 35'(r_nvy))};
            end
            S_KRD: begin
                rd_addr = r_k[AW-1:0];
            end
            S_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = n_b;
            end
            S_WRA: begin
                ram_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // integrate and wall detection from fresh memory data
    logic signed [31:0] int_px;
    logic signed [31:0] int_py;
    logic signed [31:0] int_vy;
    logic signed [34:0] hi_x;
    logic signed [34:0] hi_y;

    always_comb begin
        int_px = bps_pkg::sat35(35'(rd.px) + 35'(rd.vx));
        int_py = bps_pkg::sat35(35'(rd.py) + 35'(rd.vy));
        int_vy = bps_pkg::sat35(35'(rd.vy) + $signed({19'd0, r_gravity}));
        hi_x   = $signed({11'd0, r_width, 16'd0});
        hi_y   = $signed({11'd0, r_height, 16'd0});
    end

    // pair separation
    logic signed [32:0] dx_w;
    logic signed [32:0] dy_w;
    logic [32:0]        adx_w;
    logic [32:0]        ady_w;
    logic               near;

    always_comb begin
        dx_w  = 33'(r_a.px) - 33'(rd.px);
        dy_w  = 33'(r_a.py) - 33'(rd.py);
        adx_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
        ady_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
        near  = (adx_w < 33'(rs)) && (ady_w < 33'(rs));
    end

    logic signed [45:0] sqx_full;
    logic signed [45:0] sqy_full;
    logic [44:0]        d2;
    logic [45:0]        sq_t;
    logic [22:0]        adx;
    logic [22:0]        ady;

    always_comb begin
        sqx_full = r_dx * r_dx;
        sqy_full = r_dy * r_dy;
        d2       = 45'(r_sqx) + 45'(r_sqy);
        sq_t     = r_sqres + r_sqbit;
        adx      = r_dx[22] ? 23'(-r_dx) : 23'(r_dx);
        ady      = r_dy[22] ? 23'(-r_dy) : 23'(r_dy);
    end

    // divider step, both axes share the divisor
    logic [24:0] shx;
    logic [24:0] shy;
    logic        qbx;
    logic        qby;

    always_comb begin
        shx = {r_remx, r_dqx[43]};
        shy = {r_remy, r_dqy[43]};
        qbx = shx >= {1'b0, r_div};
        qby = shy >= {1'b0, r_div};
    end

    // pair update
    logic signed [34:0] ppx;
    logic signed [34:0] ppy;
    logic signed [34:0] pqx;
    logic signed [34:0] pqy;

    always_comb begin
        ppx = r_dx[22] ? -$signed({11'd0, r_dqx[23:0]}) : $signed({11'd0, r_dqx[23:0]});
        ppy = r_dy[22] ? -$signed({11'd0, r_dqy[23:0]}) : $signed({11'd0, r_dqy[23:0]});
        pqx = r_dx[22] ? -$signed({13'd0, r_dqx[23:2]}) : $signed({13'd0, r_dqx[23:2]});
        pqy = r_dy[22] ? -$signed({13'd0, r_dqy[23:2]}) : $signed({13'd0, r_dqy[23:2]});
        n_a.px = bps_pkg::sat35(35'(r_a.px) + ppx);
        n_a.py = bps_pkg::sat35(35'(r_a.py) + ppy);
        n_a.vx = bps_pkg::sat35(35'(r_a.vx) + pqx);
        n_a.vy = bps_pkg::sat35(35'(r_a.vy) + pqy);
        n_b.px = bps_pkg::sat35(35'(r_b.px) - ppx);
        n_b.py = bps_pkg::sat35(35'(r_b.py) - ppy);
        n_b.vx = bps_pkg::sat35(35'(r_b.vx) - pqx);
        n_b.vy = bps_pkg::sat35(35'(r_b.vy) - pqy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_gravity <= 16'd643;
            r_bounce  <= 17'd52429;
            r_radius  <= 21'd65536;
            r_width   <= 8'd80;
            r_height  <= 8'd24;
            r_i       <= '0;
            r_k       <= '0;
            r_cnt     <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bps_pkg::CFG_GRAVITY: r_gravity <= i_cfg_data[15:0];
                    bps_pkg::CFG_BOUNCE:  r_bounce  <= i_cfg_data[16:0];
                    bps_pkg::CFG_RADIUS:  r_radius  <= i_cfg_data;
                    bps_pkg::CFG_WIDTH:   r_width   <= i_cfg_data[7:0];
                    bps_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_kind == bps_pkg::KIND_TICK)) begin
                        r_i     <= '0;
                        r_k     <= CW'(1);
                        r_state <= S_RDA;
                    end else if (accept && (i_kind == bps_pkg::KIND_NUDGE) && idx_ok) begin
                        r_state <= S_NWR;
                    end
                end
                S_NWR: r_state <= S_IDLE;
                S_RDA: r_state <= S_INT;
                S_INT: r_state <= S_WY;
                S_WY:  r_state <= S_WX;
                S_WX:  r_state <= S_KRD;
                S_KRD: begin
                    r_state <= (r_k == CW'(BALLS)) ? S_WRA : S_P0;
                end
                S_P0: begin
                    if (near) begin
                        r_state <= S_P1;
                    end else begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_KRD;
                    end
                end
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_P4;
                S_P4: begin
                    r_cnt <= '0;
                    if ((d2 == '0) || (d2 >= 45'(r_rs2))) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_KRD;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd22) begin
                        r_state <= S_OV;
                    end
                end
                S_OV: r_state <= S_MX;
                S_MX: r_state <= S_MY;
                S_MY: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd43) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_k     <= r_k + CW'(1);
                    r_state <= S_KRD;
                end
                S_WRA: begin
                    o_valid <= 1'b1;
                    if (r_i == CW'(BALLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_k     <= r_i + CW'(2);
                        r_state <= S_RDA;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_rd_addr <= rd_addr;
        case (r_state)
            S_IDLE: begin
                r_idx <= idx_w[AW-1:0];
                r_nvx <= i_vel_x;
                r_nvy <= i_vel_y;
            end
            S_INT: begin
                r_a.vx <= rd.vx;
                r_a.vy <= int_vy;
                r_wy   <= 1'b0;
                r_wx   <= 1'b0;
                r_a.py <= int_py;
                r_a.px <= int_px;
                if (int_py < 0) begin
                    r_a.py <= bps_pkg::ONE_Q16;
                    r_wy   <= 1'b1;
                end else if (35'(int_py) > hi_y) begin
                    r_a.py <= 32'(hi_y - 35'sd65536);
                    r_wy   <= 1'b1;
                end
                if (int_px < 0) begin
                    r_a.px <= bps_pkg::ONE_Q16;
                    r_wx   <= 1'b1;
                end else if (35'(int_px) > hi_x) begin
                    r_a.px <= 32'(hi_x - 35'sd65536);
                    r_wx   <= 1'b1;
                end
            end
            S_WY: begin
                if (r_wy) begin
                    r_a.vy <= bps_pkg::reflect(r_a.vy, r_bounce);
                end
            end
            S_WX: begin
                if (r_wx) begin
                    r_a.vx <= bps_pkg::reflect(r_a.vx, r_bounce);
                end
            end
            S_P0: begin
                r_b  <= rd;
                r_dx <= dx_w[22:0];
                r_dy <= dy_w[22:0];
            end
            S_P1: r_sqx <= sqx_full[43:0];
            S_P2: r_sqy <= sqy_full[43:0];
            S_P3: r_rs2 <= rs * rs;
            S_P4: begin
                r_sqn   <= 46'(d2);
                r_sqres <= '0;
                r_sqbit <= 46'(1) << 44;
            end
            S_SQ: begin
                if (r_sqn >= sq_t) begin
                    r_sqn   <= r_sqn - sq_t;
                    r_sqres <= (r_sqres >> 1) + r_sqbit;
                end else begin
                    r_sqres <= r_sqres >> 1;
                end
                r_sqbit <= r_sqbit >> 2;
            end
            S_OV: begin
                r_d  <= r_sqres[22:0];
                r_ov <= rs - r_sqres[21:0];
            end
            S_MX: r_dqx <= adx[21:0] * r_ov;
            S_MY: begin
                r_dqy  <= ady[21:0] * r_ov;
                r_div  <= {r_d, 1'b0};
                r_remx <= '0;
                r_remy <= '0;
            end
            S_DIV: begin
                r_remx <= qbx ? 24'(shx - {1'b0, r_div}) : shx[23:0];
                r_remy <= qby ? 24'(shy - {1'b0, r_div}) : shy[23:0];
                r_dqx  <= {r_dqx[42:0], qbx};
                r_dqy  <= {r_dqy[42:0], qby};
            end
            S_UPD: r_a <= n_a;
            S_WRA: begin
                o_out_index <= out_idx_w[2:0];
                o_out_x     <= r_a.px;
                o_out_y     <= r_a.py;
                o_last_ball <= (r_i == CW'(BALLS - 1));
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/bps_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bps_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/bps_checker.sv @@
// Port-level checker for the ball physics step unit, bound to the top level.
`timescale 1ns / 1ps

module bps_checker #(
    parameter int BALLS = 8
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_out_index,
    input logic       o_last_ball
);

    localparam logic [2:0] LAST_IDX = 3'((BALLS - 1) % 8);

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_ball |-> o_busy)
        else $error("result before the last ball while block is idle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_ball |-> !o_busy && (o_out_index == LAST_IDX))
        else $error("last result with wrong index or block still busy");

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back result strobes");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_busy && !o_valid)
        else $error("block not idle after reset");

endmodule

bind ball_physics_step_unit bps_checker #(.BALLS(BALLS)) u_bps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_out_index (o_out_index),
    .o_last_ball (o_last_ball)
);

@@ verif/tb_ball_physics_step_unit.sv @@
// Self-checking testbench for ball_physics_step_unit: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module tb_ball_physics_step_unit;

    localparam int NBALL = 8;
    localparam int WDOG_LIMIT = 30000;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef struct {
        logic [2:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } t_pos_out;

    typedef struct {
        logic [1:0]         kind;
        logic [2:0]         idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        bit                 fixed;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic [1:0]         i_kind;
    logic [2:0]         i_ball_index;
    logic signed [31:0] i_pos_x;
    logic signed [31:0] i_pos_y;
    logic signed [31:0] i_vel_x;
    logic signed [31:0] i_vel_y;
    logic               i_cfg_we;
    logic [bps_pkg::CFG_IW-1:0] i_cfg_index;
    logic [bps_pkg::CFG_DW-1:0] i_cfg_data;
    logic               o_busy;
    logic               o_valid;
    logic [2:0]         o_out_index;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_last_ball;

    ball_physics_step_unit #(.BALLS(NBALL)) dut (.*);

    // model state
    logic signed [31:0] bx[NBALL], by[NBALL], bvx[NBALL], bvy[NBALL];
    logic [15:0] m_grav;
    logic [16:0] m_bounce;
    logic [20:0] m_radius;
    logic [7:0]  m_width, m_height;

    t_pos_out pos_q[$];
    bit fixed_on;
    logic signed [31:0] fixed_x, fixed_y;
    bit idle_on;
    int errors, n_ticks, n_loads, n_nudges, n_results, wdog;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] sat(input longint v);
        if (v > SMAX) return 32'sh7fffffff;
        if (v < SMIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] bounce_vel(input logic signed [31:0] v);
        longint p;
        p = -(longint'(v) * longint'({15'd0, m_bounce}));
        return sat(p >>> 16);
    endfunction

    function automatic longint int_sqrt(input longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic apply_wall(inout logic signed [31:0] p, inout logic signed [31:0] v,
                              input logic [7:0] w);
        longint hi;
        hi = longint'(w) * 65536;
        if (p < 0) begin
            p = bps_pkg::ONE_Q16;
            v = bounce_vel(v);
        end else if (longint'(p) > hi) begin
            p = sat(hi - 65536);
            v = bounce_vel(v);
        end
    endtask

    task automatic separate_pair(input int i, input int k);
        longint rs, dx, dy, d2, d, ov, px, py, qx, qy;
        rs = 2 * longint'(m_radius);
        dx = longint'(bx[i]) - longint'(bx[k]);
        dy = longint'(by[i]) - longint'(by[k]);
        if ((dx < 0 ? -dx : dx) >= rs || (dy < 0 ? -dy : dy) >= rs) return;
        d2 = dx * dx + dy * dy;
        if (d2 == 0 || d2 >= rs * rs) return;
        d = int_sqrt(d2);
        if (d == 0) return;
        ov = rs - d;
        px = (dx * ov) / (2 * d);
        py = (dy * ov) / (2 * d);
        qx = (dx * ov) / (8 * d);
        qy = (dy * ov) / (8 * d);
        bx[i]  = sat(longint'(bx[i]) + px);
        by[i]  = sat(longint'(by[i]) + py);
        bx[k]  = sat(longint'(bx[k]) - px);
        by[k]  = sat(longint'(by[k]) - py);
        bvx[i] = sat(longint'(bvx[i]) + qx);
        bvy[i] = sat(longint'(bvy[i]) + qy);
        bvx[k] = sat(longint'(bvx[k]) - qx);
        bvy[k] = sat(longint'(bvy[k]) - qy);
    endtask

    task automatic predict_request();
        t_pos_out e;
        logic signed [31:0] tp, tv;
        case (i_kind)
            bps_pkg::KIND_LOAD: begin
                bx[i_ball_index] = i_pos_x;
                by[i_ball_index] = i_pos_y;
                bvx[i_ball_index] = i_vel_x;
                bvy[i_ball_index] = i_vel_y;
                n_loads++;
            end
            bps_pkg::KIND_NUDGE: begin
                bvx[i_ball_index] = sat(longint'(bvx[i_ball_index]) + longint'(i_vel_x));
                bvy[i_ball_index] = sat(longint'(bvy[i_ball_index]) + longint'(i_vel_y));
                n_nudges++;
            end
            bps_pkg::KIND_TICK: begin
                n_ticks++;
                for (int i = 0; i < NBALL; i++) begin
                    by[i] = sat(longint'(by[i]) + longint'(bvy[i]));
                    bx[i] = sat(longint'(bx[i]) + longint'(bvx[i]));
                    bvy[i] = sat(longint'(bvy[i]) + longint'(m_grav));
                    tp = by[i]; tv = bvy[i];
                    apply_wall(tp, tv, m_height);
                    by[i] = tp; bvy[i] = tv;
                    tp = bx[i]; tv = bvx[i];
                    apply_wall(tp, tv, m_width);
                    bx[i] = tp; bvx[i] = tv;
                    for (int k = i + 1; k < NBALL; k++) separate_pair(i, k);
                    e.idx = i[2:0];
                    e.x = fixed_on ? fixed_x : bx[i];
                    e.y = fixed_on ? fixed_y : by[i];
                    e.last = (i == NBALL - 1);
                    pos_q.push_back(e);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_pos_out e;
        if (i_rst_n) begin
            if ((i_start && !o_busy) || o_valid) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (i_start && !o_busy) begin
                predict_request();
            end
            if (o_valid) begin
                n_results++;
                if (pos_q.size() == 0) begin
                    $error("unexpected result for ball %0d", o_out_index);
                    errors++;
                end else begin
                    e = pos_q.pop_front();
                    if (o_out_index !== e.idx) begin
                        $error("out_index exp %0d got %0d", e.idx, o_out_index); errors++;
                    end
                    if (o_out_x !== e.x) begin
                        $error("out_x exp %0d got %0d", e.x, o_out_x); errors++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y exp %0d got %0d", e.y, o_out_y); errors++;
                    end
                    if (o_last_ball !== e.last) begin
                        $error("last_ball exp %0d got %0d", e.last, o_last_ball); errors++;
                    end
                end
            end
            if (wdog >= WDOG_LIMIT) begin
                $display("watchdog timeout");
                $display("** ball_physics_step_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic send(input t_row r);
        while (idle_on && $urandom_range(99) < 19) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_kind = r.kind;
        i_ball_index = r.idx;
        i_pos_x = r.px;
        i_pos_y = r.py;
        i_vel_x = r.vx;
        i_vel_y = r.vy;
        fixed_on = r.fixed;
        fixed_x = r.fx;
        fixed_y = r.fy;
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
        i_start = 1'b0;
        fixed_on = 1'b0;
    endtask

    task automatic drain();
        while (pos_q.size() != 0 || o_busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [bps_pkg::CFG_IW-1:0] idx,
                             input logic [bps_pkg::CFG_DW-1:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        case (idx)
            bps_pkg::CFG_GRAVITY: m_grav = val[15:0];
            bps_pkg::CFG_BOUNCE:  m_bounce = val[16:0];
            bps_pkg::CFG_RADIUS:  m_radius = val;
            bps_pkg::CFG_WIDTH:   m_width = val[7:0];
            bps_pkg::CFG_HEIGHT:  m_height = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_all(input int g, input int b, input int rad, input int w, input int h);
        drain();
        write_reg(bps_pkg::CFG_GRAVITY, bps_pkg::CFG_DW'(g));
        write_reg(bps_pkg::CFG_BOUNCE, bps_pkg::CFG_DW'(b));
        write_reg(bps_pkg::CFG_RADIUS, bps_pkg::CFG_DW'(rad));
        write_reg(bps_pkg::CFG_WIDTH, bps_pkg::CFG_DW'(w));
        write_reg(bps_pkg::CFG_HEIGHT, bps_pkg::CFG_DW'(h));
    endtask

    function automatic t_row mk(input logic [1:0] k, input logic [2:0] n,
                                input int px, input int py, input int vx, input int vy);
        t_row r;
        r.kind = k; r.idx = n; r.px = px; r.py = py; r.vx = vx; r.vy = vy;
        r.fixed = 1'b0; r.fx = 0; r.fy = 0;
        return r;
    endfunction

    function automatic t_row rand_row(input int cfg_w, input int cfg_h);
        t_row r;
        int sel;
        sel = $urandom_range(99);
        r = mk(bps_pkg::KIND_LOAD, 3'($urandom_range(7)), $urandom, $urandom, $urandom,
               $urandom);
        if (sel < 30) begin
            r.kind = bps_pkg::KIND_TICK;
        end else if (sel < 70) begin
            // clustered balls so pairs touch
            r.px = $urandom_range(cfg_w * 65536 / 2 + 3 * 65536, cfg_w * 65536 / 2);
            r.py = $urandom_range(cfg_h * 65536 / 2 + 3 * 65536, cfg_h * 65536 / 2);
            r.vx = int'($urandom_range(65536)) - 32768;
            r.vy = int'($urandom_range(65536)) - 32768;
        end else if (sel < 85) begin
            r.kind = bps_pkg::KIND_NUDGE;
            if (sel < 80) begin
                r.vx = int'($urandom_range(32768)) - 16384;
                r.vy = int'($urandom_range(32768)) - 16384;
            end
        end else if (sel < 90) begin
            r.kind = 2'd3;
        end
        return r;
    endfunction

    t_row dir_tab[$];

    initial begin
        int w, h;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_kind = bps_pkg::KIND_TICK;
        i_ball_index = '0;
        i_pos_x = '0; i_pos_y = '0; i_vel_x = '0; i_vel_y = '0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        fixed_on = 1'b0; fixed_x = 0; fixed_y = 0;
        idle_on = 1'b1;
        errors = 0; n_ticks = 0; n_loads = 0; n_nudges = 0; n_results = 0; wdog = 0;
        m_grav = 643; m_bounce = 52429; m_radius = 65536; m_width = 80; m_height = 24;
        for (int i = 0; i < NBALL; i++) begin
            bx[i] = 0; by[i] = 0; bvx[i] = 0; bvy[i] = 0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // all balls at rest at the origin: zero distance, stays put
        dir_tab.push_back(mk(bps_pkg::KIND_TICK, 0, 0, 0, 0, 0));
        dir_tab[0].fixed = 1'b1;
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 0, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 1, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000));
        dir_tab.push_back(mk(bps_pkg::KIND_NUDGE, 0, 0, 0, 32'h7fffffff, 32'h7fffffff));
        dir_tab.push_back(mk(bps_pkg::KIND_NUDGE, 1, 0, 0, 32'h80000000, 32'h80000000));
        dir_tab.push_back(mk(2'd3, 2, 32'h12345, 32'h54321, 32'h1000, 32'h1000));
        dir_tab.push_back(mk(bps_pkg::KIND_TICK, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 2, 10 << 16, 10 << 16, 65536, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 3, (10 << 16) + 40000, (10 << 16) + 20000,
                             -65536, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 4, 30 << 16, 12 << 16, 0, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 5, 30 << 16, 12 << 16, 0, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 6, 79 << 16, 23 << 16, 5 << 16, 5 << 16));
        dir_tab.push_back(mk(bps_pkg::KIND_LOAD, 7, 1 << 16, 1 << 16, -(5 << 16),
                             -(5 << 16)));
        dir_tab.push_back(mk(bps_pkg::KIND_TICK, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_NUDGE, 2, 0, 0, -32768, 16384));
        dir_tab.push_back(mk(bps_pkg::KIND_TICK, 0, 0, 0, 0, 0));
        dir_tab.push_back(mk(bps_pkg::KIND_TICK, 0, 0, 0, 0, 0));
        foreach (dir_tab[j]) send(dir_tab[j]);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_all(643, 52429, 65536, 80, 24);
                1: set_all(0, 0, 0, 1, 1);
                2: set_all(65535, 65536, 1048576, 255, 255);
                3: set_all(0, 65536, 21'h1fffff, 0, 0);
                4: set_all($urandom_range(65535), $urandom_range(65536),
                           $urandom_range(1048576), $urandom_range(255, 1),
                           $urandom_range(255, 1));
                default: set_all(643, 52429, 3 * 65536, 40, 20);
            endcase
            idle_on = (ph != 2);
            w = (m_width == 0) ? 1 : m_width;
            h = (m_height == 0) ? 1 : m_height;
            for (int j = 0; j < 60; j++) send(rand_row(w, h));
        end

        drain();
        repeat (50) @(negedge i_clk);
        $display("covered %0d ticks, %0d loads, %0d nudges, %0d positions checked",
                 n_ticks, n_loads, n_nudges, n_results);
        $display("six register settings including both extremes of every register");
        if (errors == 0 && pos_q.size() == 0) begin
            $display("** ball_physics_step_unit: PASSED **");
        end else begin
            $display("** ball_physics_step_unit: FAILED **");
        end
        $finish;
    end

endmodule
